### rtl/core/bbu_pkg.sv
// shared types and constants for the billboard basis unit
package bbu_pkg;

	localparam int POS_W  = 24;
	localparam int UNIT_W = 16;
	localparam int UNIT_FRAC_BITS = 14;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_CAM_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAM_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CAM_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UP_X  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UP_Y  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_UP_Z  = 3'd5;

	localparam logic OP_SPHERICAL   = 1'b0;
	localparam logic OP_CYLINDRICAL = 1'b1;

	typedef struct packed {
		logic               opcode;
		logic signed [23:0] object_x;
		logic signed [23:0] object_y;
		logic signed [23:0] object_z;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] right_x;
		logic signed [15:0] right_y;
		logic signed [15:0] right_z;
		logic signed [15:0] upward_x;
		logic signed [15:0] upward_y;
		logic signed [15:0] upward_z;
		logic signed [15:0] facing_x;
		logic signed [15:0] facing_y;
		logic signed [15:0] facing_z;
		logic               degenerate;
	} out_item_t;

endpackage

### rtl/core/billboard_basis_unit.sv
// top level of the billboard basis unit: config registers and the full pipeline
// pipeline: 2*N + 6 register stages, N = 28 + UNIT_FRAC_BITS per normalizer
//   (4 front, 22 isqrt, UNIT_FRAC_BITS+2 divide); default 90 stages
// throughput: one beat per cycle, every stage is pipelined; the whole chain moves
//   on a single enable that holds while the output beat is stalled
// reset: camera at origin, view up (0, 1, 0), pipeline empty
module billboard_basis_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  bbu_pkg::in_item_t             in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output bbu_pkg::out_item_t            out_data,
	input  logic                          cfg_we,
	input  logic [bbu_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bbu_pkg::POS_W-1:0]     cfg_data
);
	localparam int UNIT_FRAC_BITS = bbu_pkg::UNIT_FRAC_BITS;
	localparam int UW = UNIT_FRAC_BITS + 2;
	localparam int PW = 2*UNIT_FRAC_BITS + 4;
	localparam int DW = bbu_pkg::POS_W + 2;
	// norm: 4 front + 22 sqrt + UW divide (registers counted in valid line)
	localparam int NORM_LAT = 4 + 22 + UW;
	localparam int TOTAL = 1 + NORM_LAT + 2 + NORM_LAT + 2 + 1;
	localparam logic signed [UW-1:0] ONE = UW'(1) << UNIT_FRAC_BITS;

	// configuration registers
	logic signed [23:0] cam_x_q, cam_y_q, cam_z_q;
	logic signed [15:0] vup_x_q, vup_y_q, vup_z_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_x_q <= '0; cam_y_q <= '0; cam_z_q <= '0;
			vup_x_q <= '0; vup_y_q <= 16'(ONE); vup_z_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bbu_pkg::REG_CAM_X: cam_x_q <= cfg_data;
				bbu_pkg::REG_CAM_Y: cam_y_q <= cfg_data;
				bbu_pkg::REG_CAM_Z: cam_z_q <= cfg_data;
				bbu_pkg::REG_UP_X:  vup_x_q <= cfg_data[15:0];
				bbu_pkg::REG_UP_Y:  vup_y_q <= cfg_data[15:0];
				bbu_pkg::REG_UP_Z:  vup_z_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// global stall: the chain advances when the last stage is empty or taken
	logic en;
	logic [TOTAL-1:0] vld_q;
	assign out_valid = vld_q[TOTAL-1];
	assign en = !out_valid || out_ready;
	assign in_ready = en;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[TOTAL-2:0], in_valid};
	end

	// stage 1: camera minus object, and the up vector chosen by opcode
	logic signed [DW-1:0] d_s1 [3];
	logic op_s1;
	logic signed [15:0] up_s1 [3];
	always_ff @(posedge clk) begin
		if (en) begin
			d_s1[0] <= DW'(cam_x_q) - DW'(in_data.object_x);
			d_s1[1] <= DW'(cam_y_q) - DW'(in_data.object_y);
			d_s1[2] <= DW'(cam_z_q) - DW'(in_data.object_z);
			op_s1 <= in_data.opcode;
			if (in_data.opcode == bbu_pkg::OP_CYLINDRICAL) begin
				up_s1[0] <= '0; up_s1[1] <= 16'(ONE); up_s1[2] <= '0;
			end else begin
				up_s1[0] <= vup_x_q; up_s1[1] <= vup_y_q; up_s1[2] <= vup_z_q;
			end
		end
	end

	// first normalize: look; opcode and up ride along
	localparam int SA = 1 + 48;
	logic signed [UW-1:0] lk [3];
	logic z1;
	logic [SA-1:0] sa_out;
	bbu_norm #(.IN_W(DW), .UFRAC(UNIT_FRAC_BITS), .SIDE_W(SA)) u_norm_look (
		.clk, .en,
		.vx(d_s1[0]), .vy(d_s1[1]), .vz(d_s1[2]),
		.side_in({op_s1, up_s1[0], up_s1[1], up_s1[2]}),
		.ox(lk[0]), .oy(lk[1]), .oz(lk[2]), .zero(z1), .side_out(sa_out)
	);
	logic signed [15:0] upa [3];
	logic opa;
	assign {opa, upa[0], upa[1], upa[2]} = sa_out;

	// look x up (view up may be up to 16 bits; sign-extend into UW)
	logic signed [PW-1:0] t1 [3];
	bbu_cross #(.UFRAC(UNIT_FRAC_BITS)) u_cross1 (
		.clk, .en,
		.ax(lk[0]), .ay(lk[1]), .az(lk[2]),
		.bx(UW'(upa[0])), .by(UW'(upa[1])), .bz(UW'(upa[2])),
		.ox(t1[0]), .oy(t1[1]), .oz(t1[2])
	);
	localparam int SB = 1 + 1 + 3*UW + 48;
	logic [SB-1:0] sb_s1, sb_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			sb_s1 <= {opa, z1, lk[0], lk[1], lk[2], upa[0], upa[1], upa[2]};
			sb_s2 <= sb_s1;
		end
	end

	// second normalize: right
	logic signed [UW-1:0] rt [3];
	logic z2;
	logic [SB-1:0] sb_out;
	bbu_norm #(.IN_W(PW), .UFRAC(UNIT_FRAC_BITS), .SIDE_W(SB)) u_norm_right (
		.clk, .en,
		.vx(t1[0]), .vy(t1[1]), .vz(t1[2]), .side_in(sb_s2),
		.ox(rt[0]), .oy(rt[1]), .oz(rt[2]), .zero(z2), .side_out(sb_out)
	);
	logic opb, z1b;
	logic signed [UW-1:0] lkb [3];
	logic signed [15:0] upb [3];
	assign {opb, z1b, lkb[0], lkb[1], lkb[2], upb[0], upb[1], upb[2]} = sb_out;

	// cylindrical: up x right; spherical: right x look
	logic signed [UW-1:0] ca [3], cb [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ca[i] = (opb == bbu_pkg::OP_CYLINDRICAL) ? UW'(upb[i]) : rt[i];
			cb[i] = (opb == bbu_pkg::OP_CYLINDRICAL) ? rt[i] : lkb[i];
		end
	end
	logic signed [PW-1:0] t2 [3];
	bbu_cross #(.UFRAC(UNIT_FRAC_BITS)) u_cross2 (
		.clk, .en,
		.ax(ca[0]), .ay(ca[1]), .az(ca[2]),
		.bx(cb[0]), .by(cb[1]), .bz(cb[2]),
		.ox(t2[0]), .oy(t2[1]), .oz(t2[2])
	);
	localparam int SC = 2 + 6*UW + 48;
	logic [SC-1:0] sc_s1, sc_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			sc_s1 <= {opb, z1b | z2, rt[0], rt[1], rt[2], lkb[0], lkb[1], lkb[2],
				upb[0], upb[1], upb[2]};
			sc_s2 <= sc_s1;
		end
	end
	logic opc, degc;
	logic signed [UW-1:0] rtc [3], lkc [3];
	logic signed [15:0] upc [3];
	assign {opc, degc, rtc[0], rtc[1], rtc[2], lkc[0], lkc[1], lkc[2],
		upc[0], upc[1], upc[2]} = sc_s2;

	// rescale 2U -> U, round half away from zero, clamp
	function automatic logic signed [UW-1:0] rescale_f(input logic signed [PW-1:0] p);
		logic [PW-1:0] a;
		logic [PW-1:0] q;
		a = p[PW-1] ? PW'(-p) : PW'(p);
		q = (a + (PW'(1) << (UNIT_FRAC_BITS-1))) >> UNIT_FRAC_BITS;
		if (q > PW'(ONE)) q = PW'(ONE);
		rescale_f = p[PW-1] ? -$signed(UW'(q)) : $signed(UW'(q));
	endfunction

	bbu_pkg::out_item_t res;
	always_comb begin
		logic signed [UW-1:0] r2 [3];
		for (int i = 0; i < 3; i++) r2[i] = rescale_f(t2[i]);
		res.degenerate = degc;
		res.right_x = 16'(rtc[0]); res.right_y = 16'(rtc[1]); res.right_z = 16'(rtc[2]);
		if (opc == bbu_pkg::OP_CYLINDRICAL) begin
			res.upward_x = upc[0]; res.upward_y = upc[1]; res.upward_z = upc[2];
			res.facing_x = 16'(r2[0]); res.facing_y = 16'(r2[1]); res.facing_z = 16'(r2[2]);
		end else begin
			res.upward_x = 16'(r2[0]); res.upward_y = 16'(r2[1]); res.upward_z = 16'(r2[2]);
			res.facing_x = 16'(lkc[0]); res.facing_y = 16'(lkc[1]); res.facing_z = 16'(lkc[2]);
		end
		if (degc) begin
			res.right_x = '0; res.right_y = '0; res.right_z = '0;
			res.upward_x = '0; res.upward_y = '0; res.upward_z = '0;
			res.facing_x = '0; res.facing_y = '0; res.facing_z = '0;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (en) out_data <= res;
	end

	// a stalled output holds its beat
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output beat changed while stalled");
	// degenerate beats carry zero rows (checked on right_x, upward_y and facing_z)
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.degenerate |-> out_data.right_x == 0 &&
		out_data.upward_y == 0 && out_data.facing_z == 0)
		else $error("degenerate beat with nonzero rows");
	// ready follows the output side only
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");
endmodule

### rtl/core/bbu_norm.sv
// pipelined 3-vector normalizer: block scale, sum of squares, isqrt, divide
module bbu_norm #(
	parameter int IN_W   = 26,
	parameter int UFRAC  = 14,
	parameter int SIDE_W = 1
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [IN_W-1:0]  vx,
	input  logic signed [IN_W-1:0]  vy,
	input  logic signed [IN_W-1:0]  vz,
	input  logic [SIDE_W-1:0]       side_in,
	output logic signed [UFRAC+1:0] ox,
	output logic signed [UFRAC+1:0] oy,
	output logic signed [UFRAC+1:0] oz,
	output logic                    zero,
	output logic [SIDE_W-1:0]       side_out
);
	// register stages: 4 + 22 (isqrt) + (UFRAC+2) (divide)
	localparam int AW = 21;
	localparam int SW = 2*AW + 2;
	localparam int RW = AW + 1;
	localparam int QW = UFRAC + 2;
	localparam int NQ = UFRAC + 2;
	localparam int NS = RW;
	localparam int SHW = $clog2(IN_W + AW + 1);
	localparam int DW = AW + UFRAC + 2;

	function automatic logic [IN_W-1:0] mag_f(input logic signed [IN_W-1:0] v);
		mag_f = v[IN_W-1] ? IN_W'(-v) : IN_W'(v);
	endfunction

	// stage 1: magnitudes, and the or of the magnitudes in place of the max
	logic [IN_W-1:0] a_s1 [3];
	logic [2:0] sg_s1;
	logic [IN_W-1:0] m_s1;
	logic [SIDE_W-1:0] sd_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			a_s1[0] <= mag_f(vx);
			a_s1[1] <= mag_f(vy);
			a_s1[2] <= mag_f(vz);
			sg_s1 <= {vx[IN_W-1], vy[IN_W-1], vz[IN_W-1]};
			sd_s1 <= side_in;
			m_s1 <= mag_f(vx) | mag_f(vy) | mag_f(vz);
		end
	end
	// or of magnitudes has the same top bit as the max

	// stage 2: leading one position -> shift
	logic [IN_W-1:0] a_s2 [3];
	logic [2:0] sg_s2;
	logic [SIDE_W-1:0] sd_s2;
	logic [SHW-1:0] lz_s2;
	logic z_s2;
	logic [SHW-1:0] lead;
	always_comb begin
		lead = '0;
		for (int i = 0; i < IN_W; i++)
			if (m_s1[i]) lead = SHW'(i);
	end
	always_ff @(posedge clk) begin
		if (en) begin
			a_s2 <= a_s1;
			sg_s2 <= sg_s1;
			sd_s2 <= sd_s1;
			lz_s2 <= lead;
			z_s2 <= (m_s1 == '0);
		end
	end

	// stage 3: scale so the largest lies in [2^20, 2^21)
	logic [AW-1:0] b_s3 [3];
	logic [2:0] sg_s3;
	logic [SIDE_W-1:0] sd_s3;
	logic z_s3;
	logic [IN_W+AW-1:0] wide [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (lz_s2 >= SHW'(AW-1))
				wide[i] = (IN_W+AW)'(a_s2[i]) >> (lz_s2 - SHW'(AW-1));
			else
				wide[i] = (IN_W+AW)'(a_s2[i]) << (SHW'(AW-1) - lz_s2);
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) b_s3[i] <= wide[i][AW-1:0];
			sg_s3 <= sg_s2;
			sd_s3 <= sd_s2;
			z_s3 <= z_s2;
		end
	end

	// stage 4: squares
	logic [2*AW-1:0] sq_s4 [3];
	logic [AW-1:0] b_s4 [3];
	logic [2:0] sg_s4;
	logic [SIDE_W-1:0] sd_s4;
	logic z_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) sq_s4[i] <= b_s3[i] * b_s3[i];
			b_s4 <= b_s3;
			sg_s4 <= sg_s3;
			sd_s4 <= sd_s3;
			z_s4 <= z_s3;
		end
	end

	// isqrt pipeline, one result bit per stage
	logic [SW-1:0] rx_p [NS+1];
	logic [SW-1:0] rr_p [NS+1];
	logic [AW-1:0] rb_p [NS+1][3];
	logic [2:0] rs_p [NS+1];
	logic [SIDE_W-1:0] rd_p [NS+1];
	logic rz_p [NS+1];
	always_comb begin
		rx_p[0] = SW'(sq_s4[0]) + SW'(sq_s4[1]) + SW'(sq_s4[2]);
		rr_p[0] = '0;
		rb_p[0] = b_s4;
		rs_p[0] = sg_s4;
		rd_p[0] = sd_s4;
		rz_p[0] = z_s4;
	end
	for (genvar k = 0; k < NS; k++) begin : g_sqrt
		localparam logic [SW-1:0] BIT = SW'(1) << (2*(NS-1-k));
		logic [SW-1:0] nx, nr;
		always_comb begin
			if (rx_p[k] >= rr_p[k] + BIT) begin
				nx = rx_p[k] - (rr_p[k] + BIT);
				nr = (rr_p[k] >> 1) + BIT;
			end else begin
				nx = rx_p[k];
				nr = rr_p[k] >> 1;
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rx_p[k+1] <= nx;
				rr_p[k+1] <= nr;
				rb_p[k+1] <= rb_p[k];
				rs_p[k+1] <= rs_p[k];
				rd_p[k+1] <= rd_p[k];
				rz_p[k+1] <= rz_p[k];
			end
		end
	end

	// restoring divide: q = (a*2^(U+1) + len) / (2 len), three lanes
	logic [DW-1:0] dn_p [NQ+1][3];
	logic [QW-1:0] dq_p [NQ+1][3];
	logic [RW:0] dl_p [NQ+1];
	logic [2:0] ds_p [NQ+1];
	logic [SIDE_W-1:0] dd_p [NQ+1];
	logic dz_p [NQ+1];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dn_p[0][i] = (DW'(rb_p[NS][i]) << (UFRAC+1)) + DW'(rr_p[NS][RW-1:0]);
			dq_p[0][i] = '0;
		end
		dl_p[0] = {rr_p[NS][RW-1:0], 1'b0};
		ds_p[0] = rs_p[NS];
		dd_p[0] = rd_p[NS];
		dz_p[0] = rz_p[NS];
	end
	// quotient < 2^(U+2) since a <= len; remainder stays below divisor
	for (genvar k = 0; k < NQ; k++) begin : g_div
		localparam int SH = NQ - 1 - k;
		logic [DW-1:0] nn [3];
		logic [QW-1:0] nq [3];
		always_comb begin
			for (int i = 0; i < 3; i++) begin
				if ((dn_p[k][i] >> SH) >= DW'(dl_p[k])) begin
					nn[i] = dn_p[k][i] - (DW'(dl_p[k]) << SH);
					nq[i] = dq_p[k][i] | (QW'(1) << SH);
				end else begin
					nn[i] = dn_p[k][i];
					nq[i] = dq_p[k][i];
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				dn_p[k+1] <= nn;
				dq_p[k+1] <= nq;
				dl_p[k+1] <= dl_p[k];
				ds_p[k+1] <= ds_p[k];
				dd_p[k+1] <= dd_p[k];
				dz_p[k+1] <= dz_p[k];
			end
		end
	end

	localparam logic [QW-1:0] ONE = QW'(1) << UFRAC;
	logic [QW-1:0] qc [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qc[i] = (dq_p[NQ][i] > ONE) ? ONE : dq_p[NQ][i];
			if (dz_p[NQ]) qc[i] = '0;
		end
		ox = ds_p[NQ][2] ? -$signed(qc[0]) : $signed(qc[0]);
		oy = ds_p[NQ][1] ? -$signed(qc[1]) : $signed(qc[1]);
		oz = ds_p[NQ][0] ? -$signed(qc[2]) : $signed(qc[2]);
		zero = dz_p[NQ];
		side_out = dd_p[NQ];
	end
endmodule

### rtl/core/bbu_cross.sv
// registered cross product of two vectors with U fraction bits, products kept at 2U fraction bits
module bbu_cross #(
	parameter int UFRAC = 14
) (
	input  logic                      clk,
	input  logic                      en,
	input  logic signed [UFRAC+1:0]   ax,
	input  logic signed [UFRAC+1:0]   ay,
	input  logic signed [UFRAC+1:0]   az,
	input  logic signed [UFRAC+1:0]   bx,
	input  logic signed [UFRAC+1:0]   by,
	input  logic signed [UFRAC+1:0]   bz,
	output logic signed [2*UFRAC+3:0] ox,
	output logic signed [2*UFRAC+3:0] oy,
	output logic signed [2*UFRAC+3:0] oz
);
	localparam int PW = 2*UFRAC + 4;
	logic signed [PW-1:0] p_s1 [6];
	always_ff @(posedge clk) begin
		if (en) begin
			p_s1[0] <= PW'(ay * bz);
			p_s1[1] <= PW'(az * by);
			p_s1[2] <= PW'(az * bx);
			p_s1[3] <= PW'(ax * bz);
			p_s1[4] <= PW'(ax * by);
			p_s1[5] <= PW'(ay * bx);
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			ox <= p_s1[0] - p_s1[1];
			oy <= p_s1[2] - p_s1[3];
			oz <= p_s1[4] - p_s1[5];
		end
	end
endmodule

### verif/tb_top.sv
// self-checking testbench for the billboard basis unit
`timescale 1ns / 1ps

typedef longint vec3_t [3];

// predicts the billboard rows for every accepted beat and checks results in order
class basis_scoreboard;
	longint cam [3];
	longint view_up [3];
	bbu_pkg::out_item_t pending_rows [$];
	int mismatches;
	int checked;
	int degenerate_seen;

	function new();
		cam = '{0, 0, 0};
		view_up = '{0, 16384, 0};
		mismatches = 0;
		checked = 0;
		degenerate_seen = 0;
	endfunction

	function void set_reg(logic [bbu_pkg::CFG_IDX_W-1:0] idx, logic [bbu_pkg::POS_W-1:0] val);
		case (idx)
			bbu_pkg::REG_CAM_X: cam[0] = longint'(signed'(val));
			bbu_pkg::REG_CAM_Y: cam[1] = longint'(signed'(val));
			bbu_pkg::REG_CAM_Z: cam[2] = longint'(signed'(val));
			bbu_pkg::REG_UP_X: view_up[0] = longint'($signed(val[bbu_pkg::UNIT_W-1:0]));
			bbu_pkg::REG_UP_Y: view_up[1] = longint'($signed(val[bbu_pkg::UNIT_W-1:0]));
			bbu_pkg::REG_UP_Z: view_up[2] = longint'($signed(val[bbu_pkg::UNIT_W-1:0]));
			default: ;
		endcase
	endfunction

	function longint unsigned floor_sqrt(longint unsigned x);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// block-scale into [2^20, 2^21), then divide by the integer length
	function bit to_unit(vec3_t v, output vec3_t o);
		longint unsigned a [3];
		longint unsigned m, len, q, sq;
		m = 0;
		for (int i = 0; i < 3; i++) begin
			a[i] = v[i] < 0 ? -v[i] : v[i];
			if (a[i] > m) m = a[i];
		end
		o = '{0, 0, 0};
		if (m == 0) return 0;
		while (m >= (64'd1 << 21)) begin
			m >>= 1;
			for (int i = 0; i < 3; i++) a[i] >>= 1;
		end
		while (m < (64'd1 << 20)) begin
			m <<= 1;
			for (int i = 0; i < 3; i++) a[i] <<= 1;
		end
		sq = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
		len = floor_sqrt(sq);
		for (int i = 0; i < 3; i++) begin
			q = ((a[i] << 15) + len) / (2 * len);
			if (q > 16384) q = 16384;
			o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
		end
		return 1;
	endfunction

	function vec3_t cross3(vec3_t a, vec3_t b);
		vec3_t o;
		o[0] = a[1] * b[2] - a[2] * b[1];
		o[1] = a[2] * b[0] - a[0] * b[2];
		o[2] = a[0] * b[1] - a[1] * b[0];
		return o;
	endfunction

	// back from 28 to 14 fraction bits, half away from zero, clamped
	function longint to_q14(longint p);
		longint unsigned a, q;
		a = p < 0 ? -p : p;
		q = (a + 8192) >> 14;
		if (q > 16384) q = 16384;
		return p < 0 ? -longint'(q) : longint'(q);
	endfunction

	function void note_input(bbu_pkg::in_item_t it);
		vec3_t d, look, up, right, t;
		bit ok;
		bit cyl;
		bbu_pkg::out_item_t e;
		cyl = (it.opcode == bbu_pkg::OP_CYLINDRICAL);
		d[0] = cam[0] - longint'(it.object_x);
		d[1] = cam[1] - longint'(it.object_y);
		d[2] = cam[2] - longint'(it.object_z);
		ok = to_unit(d, look);
		if (cyl) up = '{0, 16384, 0};
		else up = view_up;
		t = cross3(look, up);
		if (ok) ok = to_unit(t, right);
		if (ok) begin
			if (cyl) begin
				t = cross3(up, right);
				for (int i = 0; i < 3; i++) look[i] = to_q14(t[i]);
			end else begin
				t = cross3(right, look);
				for (int i = 0; i < 3; i++) up[i] = to_q14(t[i]);
			end
		end else begin
			right = '{0, 0, 0};
			up = '{0, 0, 0};
			look = '{0, 0, 0};
		end
		e.right_x = right[0][15:0];
		e.right_y = right[1][15:0];
		e.right_z = right[2][15:0];
		e.upward_x = up[0][15:0];
		e.upward_y = up[1][15:0];
		e.upward_z = up[2][15:0];
		e.facing_x = look[0][15:0];
		e.facing_y = look[1][15:0];
		e.facing_z = look[2][15:0];
		e.degenerate = !ok;
		pending_rows.push_back(e);
	endfunction

	function void check_result(bbu_pkg::out_item_t got);
		bbu_pkg::out_item_t e;
		string names [10];
		int ev [10];
		int gv [10];
		if (pending_rows.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("error: result beat with nothing pending");
			return;
		end
		e = pending_rows.pop_front();
		checked++;
		if (e.degenerate) degenerate_seen++;
		names = '{"right_x", "right_y", "right_z", "upward_x", "upward_y", "upward_z",
			"facing_x", "facing_y", "facing_z", "degenerate"};
		ev = '{e.right_x, e.right_y, e.right_z, e.upward_x, e.upward_y, e.upward_z,
			e.facing_x, e.facing_y, e.facing_z, int'(e.degenerate)};
		gv = '{got.right_x, got.right_y, got.right_z, got.upward_x, got.upward_y,
			got.upward_z, got.facing_x, got.facing_y, got.facing_z, int'(got.degenerate)};
		for (int i = 0; i < 10; i++) begin
			if (ev[i] !== gv[i]) begin
				mismatches++;
				if (mismatches <= 10)
					$display("error: result %0d field %s expected %0d got %0d",
						checked, names[i], ev[i], gv[i]);
			end
		end
	endfunction
endclass

module tb_top;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int LATENCY = 90;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	bbu_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	bbu_pkg::out_item_t out_data;
	logic cfg_we = 1'b0;
	logic [bbu_pkg::CFG_IDX_W-1:0] cfg_index = bbu_pkg::REG_CAM_X;
	logic [bbu_pkg::POS_W-1:0] cfg_data = '0;

	basis_scoreboard rows_sb = new();
	int idle_cycles = 0;
	// when set both sides run without gaps
	bit no_gaps = 0;
	int beats_sent = 0;

	always #5 clk = ~clk;

	billboard_basis_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// sample handshakes with pre-edge values; also the no-progress watchdog
	always @(posedge clk) begin
		if (in_valid && in_ready) rows_sb.note_input(in_data);
		if (out_valid && out_ready) rows_sb.check_result(out_data);
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("error: no beat moved for %0d cycles", WATCHDOG_LIMIT);
			$display("tb_top: FAIL");
			$finish;
		end
	end

	// receiver: random stall before each result beat
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = no_gaps ? 0 : $urandom_range(0, 16);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// one input beat, gap drawn first; valid stays up across back-to-back beats
	task automatic send_beat(logic op, logic signed [23:0] ox, logic signed [23:0] oy,
		logic signed [23:0] oz);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{opcode: op, object_x: ox, object_y: oy, object_z: oz};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		beats_sent++;
	endtask

	// stop sending and let the pipeline drain
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (rows_sb.pending_rows.size() != 0) @(posedge clk);
	endtask

	// register write only while idle; scoreboard copy follows; caller drops the enable
	task automatic write_reg(logic [bbu_pkg::CFG_IDX_W-1:0] idx, int val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[bbu_pkg::POS_W-1:0];
		@(posedge clk);
		rows_sb.set_reg(idx, val[bbu_pkg::POS_W-1:0]);
	endtask

	task automatic set_scene(int cx, int cy, int cz, int ux, int uy, int uz);
		drain();
		write_reg(bbu_pkg::REG_CAM_X, cx);
		write_reg(bbu_pkg::REG_CAM_Y, cy);
		write_reg(bbu_pkg::REG_CAM_Z, cz);
		write_reg(bbu_pkg::REG_UP_X, ux);
		write_reg(bbu_pkg::REG_UP_Y, uy);
		write_reg(bbu_pkg::REG_UP_Z, uz);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// random object: mostly spread out, some near the camera or on its vertical
	task automatic random_beat();
		logic op;
		int ox, oy, oz;
		int kind;
		op = $urandom_range(0, 1) ? bbu_pkg::OP_CYLINDRICAL : bbu_pkg::OP_SPHERICAL;
		kind = $urandom_range(0, 9);
		ox = $urandom;
		oy = $urandom;
		oz = $urandom;
		if (kind == 0) begin
			// object sits on the camera
			ox = int'(rows_sb.cam[0]);
			oy = int'(rows_sb.cam[1]);
			oz = int'(rows_sb.cam[2]);
		end else if (kind == 1) begin
			// straight above or below: vertical look
			ox = int'(rows_sb.cam[0]);
			oz = int'(rows_sb.cam[2]);
		end else if (kind <= 3) begin
			// small offsets exercise heavy up-scaling
			ox = int'(rows_sb.cam[0]) + $signed($urandom_range(0, 8)) - 4;
			oy = int'(rows_sb.cam[1]) + $signed($urandom_range(0, 8)) - 4;
			oz = int'(rows_sb.cam[2]) + $signed($urandom_range(0, 8)) - 4;
		end
		send_beat(op, ox[23:0], oy[23:0], oz[23:0]);
	endtask

	initial begin
		int scene [5][6];
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset scene: camera at origin, view up +y
		no_gaps = 1;
		send_beat(bbu_pkg::OP_SPHERICAL, 24'sd0, 24'sd0, 24'sd0);
		send_beat(bbu_pkg::OP_CYLINDRICAL, 24'sd0, 24'sd0, 24'sd0);
		send_beat(bbu_pkg::OP_SPHERICAL, 24'sd0, -24'sd256, 24'sd0);
		send_beat(bbu_pkg::OP_CYLINDRICAL, 24'sd0, 24'sd1000, 24'sd0);
		send_beat(bbu_pkg::OP_SPHERICAL, 24'sd0, 24'sd0, -24'sd256);
		send_beat(bbu_pkg::OP_CYLINDRICAL, 24'sd256, 24'sd0, 24'sd0);
		no_gaps = 0;
		send_beat(bbu_pkg::OP_SPHERICAL, 24'h7fffff, 24'h7fffff, 24'h7fffff);
		send_beat(bbu_pkg::OP_CYLINDRICAL, 24'h800000, 24'h800000, 24'h800000);
		send_beat(bbu_pkg::OP_SPHERICAL, 24'h800000, 24'h7fffff, 24'sd1);
		send_beat(bbu_pkg::OP_CYLINDRICAL, 24'sd1, 24'sd0, 24'sd0);
		send_beat(bbu_pkg::OP_SPHERICAL, 24'sd3, 24'sd4, 24'sd5);

		// zero view up: spherical degenerates, cylindrical ignores it
		set_scene(0, 0, 0, 0, 0, 0);
		send_beat(bbu_pkg::OP_SPHERICAL, 24'sd100, 24'sd200, 24'sd300);
		send_beat(bbu_pkg::OP_CYLINDRICAL, 24'sd100, 24'sd200, 24'sd300);
		// camera at the extremes, unnormalized tilted view up
		set_scene(8388607, -8388608, 8388607, 16384, 16384, -16384);
		send_beat(bbu_pkg::OP_SPHERICAL, 24'h800000, 24'h7fffff, 24'h800000);
		send_beat(bbu_pkg::OP_CYLINDRICAL, 24'h800000, 24'h7fffff, 24'h800000);
		send_beat(bbu_pkg::OP_SPHERICAL, 24'h7fffff, 24'h800000, 24'h7fffff);
		send_beat(bbu_pkg::OP_SPHERICAL, 24'h7ffffe, 24'h7fffff, 24'h7ffffe);
		// look parallel to view up along x
		set_scene(0, 0, 0, -16384, 0, 0);
		send_beat(bbu_pkg::OP_SPHERICAL, 24'sd512, 24'sd0, 24'sd0);
		send_beat(bbu_pkg::OP_SPHERICAL, -24'sd512, 24'sd0, 24'sd0);
		send_beat(bbu_pkg::OP_CYLINDRICAL, 24'sd512, 24'sd0, 24'sd0);

		// random phases over several scenes, including the extremes
		scene = '{'{0, 0, 0, 0, 16384, 0},
			'{-8388608, 8388607, -8388608, 16384, -16384, 16384},
			'{1000, -2000, 3000, 5000, 12000, -7000},
			'{8388607, 8388607, 8388607, 0, 0, 16384},
			'{-500, 0, 700, -16384, 1, 0}};
		for (int p = 0; p < 5; p++) begin
			if (p == 2) set_scene($urandom, $urandom, $urandom,
				$urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384,
				$urandom_range(0, 32768) - 16384);
			else set_scene(scene[p][0], scene[p][1], scene[p][2], scene[p][3],
				scene[p][4], scene[p][5]);
			for (int k = 0; k < 100; k++) begin
				// occasional stretches with no gaps at all
				if (k % 25 == 0) no_gaps = ($urandom_range(0, 2) == 0);
				random_beat();
			end
			no_gaps = 0;
		end

		drain();
		repeat (LATENCY + 20) @(posedge clk);
		$display("covered %0d input beats, %0d results checked, %0d degenerate",
			beats_sent, rows_sb.checked, rows_sb.degenerate_seen);
		$display("both modes over nine camera and view-up settings, %0d mismatches",
			rows_sb.mismatches);
		if (rows_sb.mismatches == 0 && rows_sb.pending_rows.size() == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/core/bbu_pkg.sv
rtl/core/bbu_norm.sv
rtl/core/bbu_cross.sv
rtl/core/billboard_basis_unit.sv
verif/tb_top.sv
